[rtl/swma_pkg.sv]
// Package for the sliding-window maximum average block: widths, defaults, shared types.
`timescale 1ns / 1ps

package swma_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int SUM_W          = 42;
    localparam int AVG_W          = 48;
    localparam int LEN_W          = 11;
    localparam int WINDOW_MAX_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    // request from the window datapath to the divider
    typedef struct packed {
        logic                    start;
        logic                    too_short;
        logic signed [SUM_W-1:0] sum;
    } div_req_t;

    // divider status back to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // one finished result
    typedef struct packed {
        logic signed [SUM_W-1:0] max_sum;
        logic signed [AVG_W-1:0] max_average;
        logic                    too_short;
    } div_res_t;

endpackage

[rtl/swma_if.sv]
// Valid/ready channel interfaces for samples in and results out.
`timescale 1ns / 1ps

interface swma_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [swma_pkg::SAMPLE_W-1:0]    sample;
    logic                                    last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface swma_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [swma_pkg::SUM_W-1:0]       max_sum;
    logic signed [swma_pkg::AVG_W-1:0]       max_average;
    logic                                    too_short;

    modport source (output valid, output max_sum, output max_average, output too_short,
                    input ready);
    modport sink   (input valid, input max_sum, input max_average, input too_short,
                    output ready);
endinterface

[rtl/swma_div.sv]
// Bit-serial restoring divider producing the fixed-point average of the best window sum.
`timescale 1ns / 1ps

module swma_div #(
    parameter int KW        = 11,
    parameter int FRAC_BITS = swma_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swma_pkg::div_req_t  req,
    input  logic [KW-1:0]       divisor,
    input  logic                take,
    output swma_pkg::div_stat_t stat,
    output swma_pkg::div_res_t  res
);
    import swma_pkg::*;

    localparam int NW = SUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_DONE} state_t;

    state_t                  state_reg;
    logic [NW-1:0]           quo_reg;
    logic [KW:0]             rem_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;
    logic                    short_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic [SUM_W-1:0]        mag;
    logic [KW:0]             rem_sh;
    logic                    qbit;
    logic [KW:0]             rem_next;
    logic [NW-1:0]           quo_next;
    logic [NW+AVG_W-1:0]     quo_ext;
    logic [AVG_W-1:0]        avg_mag;

    // magnitude of the captured sum; the most negative value maps to 2^41 unsigned
    assign mag = sum_reg[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum_reg)) : SUM_W'(sum_reg);

    // one quotient bit per cycle
    always_comb
    begin
        rem_sh = {rem_reg[KW-1:0], quo_reg[NW-1]};
        qbit   = (rem_sh >= {1'b0, divisor});
        rem_next = qbit ? (rem_sh - {1'b0, divisor}) : rem_sh;
        quo_next = {quo_reg[NW-2:0], qbit};
    end

    // quotient cut to the average width
    assign quo_ext = {{AVG_W{1'b0}}, quo_reg};
    assign avg_mag = quo_ext[AVG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        short_reg <= req.too_short;
                        sum_reg   <= req.sum;
                        neg_reg   <= req.sum[SUM_W-1];
                        state_reg <= req.too_short ? S_DONE : S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    quo_reg   <= {mag, {FRAC_BITS{1'b0}}};
                    rem_reg   <= '0;
                    cnt_reg   <= CNT_W'(NW);
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (take)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);

    // short arrays report zero sums
    always_comb
    begin
        res.too_short = short_reg;
        if (short_reg)
        begin
            res.max_sum     = '0;
            res.max_average = '0;
        end
        else
        begin
            res.max_sum     = sum_reg;
            res.max_average = neg_reg ? (AVG_W'(0) - avg_mag) : avg_mag;
        end
    end

endmodule

[rtl/sliding_window_max_average.sv]
// Top level: ring-store window sums with best-sum tracking and a serial average divider.
`timescale 1ns / 1ps
//
//  Channel   Dir  Flow          Payload
//  samples   in   valid/ready   sample (s32), last
//  results   out  valid/ready   max_sum (s42), max_average (s48, Q.FRAC_BITS), too_short
//  cfg       in   write enable  cfg_wdata = window_len (11 bits)
//
//  Samples are taken one per cycle while the divider is idle and no last sample is pending:
//  a ring-store read is issued at accept and the sum is updated and the sample written back
//  in the following cycle (same-entry reuse forwarded). A sample flagged last starts the
//  divider: a load step, then 42 + FRAC_BITS quotient steps. The next sample is taken only
//  after the divider has handed its result to the output register (a too-short array skips
//  the load and quotient steps); a result that waits for the output register holds it off.
//  Reset clears counters and sums at once; the ring store needs no clearing pass.
//  A result waiting in the output register does not stop further samples.

module sliding_window_max_average #(
    parameter int WINDOW_MAX = swma_pkg::WINDOW_MAX_DEF,
    parameter int FRAC_BITS  = swma_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    swma_in_if.sink                     samples,
    swma_out_if.source                  results,
    input  logic                        cfg_we,
    input  logic [swma_pkg::LEN_W-1:0]  cfg_wdata
);
    import swma_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int PW = CW + 1;

    // configuration and front-end counters
    logic [LEN_W-1:0]        window_len_reg;
    logic [AW-1:0]           wp_reg;
    logic [CW-1:0]           fill_reg;

    // stage holding the accepted sample while the store read completes
    logic                    s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic                    s1_last_reg;
    logic [AW-1:0]           s1_wp_reg;
    logic                    s1_use_old_reg;
    logic [CW-1:0]           s1_fill_reg;

    // ring store and forwarding
    logic [SAMPLE_W-1:0]     mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0]     rdata_reg;
    logic                    fwd_reg;
    logic [SAMPLE_W-1:0]     fwd_data_reg;

    // window sums
    logic signed [SUM_W-1:0] running_sum_reg;
    logic signed [SUM_W-1:0] best_sum_reg;

    // output register
    logic                    out_valid_reg;
    div_res_t                out_res_reg;

    logic [31:0]             k_wide;
    logic [CW-1:0]           k;
    logic [PW-1:0]           rd_tmp;
    logic [AW-1:0]           rd_addr;
    logic                    accept;
    logic [SAMPLE_W-1:0]     old_val;
    logic signed [SUM_W-1:0] acc;
    logic [CW-1:0]           fill_new;
    logic signed [SUM_W-1:0] best_next;
    logic                    full_new;

    div_req_t                div_req;
    div_stat_t               div_st;
    div_res_t                div_res;
    logic                    out_load;

    // effective window length: zero acts as one, large values saturate
    always_comb
    begin
        if (window_len_reg == '0)
            k_wide = 32'd1;
        else if (32'(window_len_reg) > 32'(WINDOW_MAX))
            k_wide = 32'(WINDOW_MAX);
        else
            k_wide = 32'(window_len_reg);
        k = k_wide[CW-1:0];
    end

    // entry leaving the window: (wp - k) mod WINDOW_MAX
    always_comb
    begin
        rd_tmp = PW'(wp_reg) + PW'(WINDOW_MAX) - PW'(k);
        if (rd_tmp >= PW'(WINDOW_MAX))
            rd_tmp = rd_tmp - PW'(WINDOW_MAX);
        rd_addr = rd_tmp[AW-1:0];
    end

    // hold off while a last sample is in flight or the divider is occupied
    assign samples.ready = !(s1_valid_reg && s1_last_reg) && !div_st.busy;
    assign accept = samples.valid && samples.ready;

    // ring store read and write
    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            mem[s1_wp_reg] <= s1_sample_reg;
    end

    // catch a read of the entry being written in the same cycle
    always_ff @(posedge clk)
    begin
        fwd_reg      <= s1_valid_reg && (rd_addr == s1_wp_reg);
        fwd_data_reg <= s1_sample_reg;
    end

    // front end: take register writes, capture the sample and advance or clear position and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= LEN_W'(1);
            wp_reg         <= '0;
            fill_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (cfg_we)
            begin
                window_len_reg <= cfg_wdata;
                wp_reg         <= '0;
                fill_reg       <= '0;
            end
            else if (accept)
            begin
                s1_last_reg <= samples.last;
                if (samples.last)
                begin
                    wp_reg   <= '0;
                    fill_reg <= '0;
                end
                else
                begin
                    wp_reg <= (wp_reg == AW'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
                    if (fill_reg < CW'(WINDOW_MAX))
                        fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg  <= samples.sample;
            s1_wp_reg      <= wp_reg;
            s1_fill_reg    <= fill_reg;
            s1_use_old_reg <= (fill_reg >= k);
        end
    end

    // window update
    always_comb
    begin
        old_val  = fwd_reg ? fwd_data_reg : rdata_reg;
        acc      = running_sum_reg + {{(SUM_W-SAMPLE_W){s1_sample_reg[SAMPLE_W-1]}},
                                      s1_sample_reg};
        if (s1_use_old_reg)
            acc = acc - {{(SUM_W-SAMPLE_W){old_val[SAMPLE_W-1]}}, old_val};
        fill_new = (s1_fill_reg < CW'(WINDOW_MAX)) ? s1_fill_reg + 1'b1 : s1_fill_reg;
        full_new = (fill_new >= k);
        best_next = best_sum_reg;
        if (full_new && (!s1_use_old_reg || acc > best_sum_reg))
            best_next = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            best_sum_reg    <= '0;
        end
        else if (cfg_we)
        begin
            running_sum_reg <= '0;
            best_sum_reg    <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                running_sum_reg <= '0;
                best_sum_reg    <= '0;
            end
            else
            begin
                running_sum_reg <= acc;
                best_sum_reg    <= best_next;
            end
        end
    end

    // hand the finished array to the divider
    assign div_req.start     = s1_valid_reg && s1_last_reg;
    assign div_req.too_short = !full_new;
    assign div_req.sum       = best_next;

    swma_div #(
        .KW        (CW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (k),
        .take    (out_load),
        .stat    (div_st),
        .res     (div_res)
    );

    // output register
    assign out_load = div_st.done && (!out_valid_reg || results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_res_reg <= div_res;
    end

    assign results.valid       = out_valid_reg;
    assign results.max_sum     = out_res_reg.max_sum;
    assign results.max_average = out_res_reg.max_average;
    assign results.too_short   = out_res_reg.too_short;

endmodule

[tb/sliding_window_max_average_tb.sv]
// Testbench for sliding_window_max_average: random valid/ready traffic checked against a predictor.
`timescale 1ns / 1ps

module sliding_window_max_average_tb;

    import swma_pkg::*;

    localparam int WMAX         = WINDOW_MAX_DEF;
    localparam int FRACB        = FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 100;   // covers the sample stage after the last transaction
    localparam int STALL_CYCLES = 600;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } sample_item_t;

    // flavors of random sample content
    typedef enum int {
        MIX_FULL,
        MIX_SMALL,
        MIX_CORNER,
        MIX_HIGH,
        MIX_LOW
    } sample_mix_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    swma_in_if  smp ();
    swma_out_if res ();

    sliding_window_max_average uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (smp),
        .results   (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // stimulus and result bookkeeping
    sample_item_t sample_q [$];
    div_res_t     best_q [$];
    int           n_queued = 0;
    int           n_taken  = 0;
    int           n_errors = 0;

    // flow control knobs
    bit steady     = 1'b0;
    int stall_req  = 0;
    int stall_seen = 0;
    int hold_left  = 0;

    // predictor state
    logic signed [SAMPLE_W-1:0] ring [0:WMAX-1];
    logic signed [SUM_W-1:0]    run_sum  = '0;
    logic signed [SUM_W-1:0]    best_sum = '0;
    int                         fill_cnt = 0;
    int                         wr_pos   = 0;
    int                         win_len  = 1;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic int eff_len(input int w);
        if (w == 0)
            return 1;
        if (w > WMAX)
            return WMAX;
        return w;
    endfunction

    function automatic void clear_window();
        run_sum  = '0;
        best_sum = '0;
        fill_cnt = 0;
        wr_pos   = 0;
    endfunction

    // fold one sample into the window sums; on last, queue the best window result
    task automatic window_step(input logic signed [SAMPLE_W-1:0] s, input logic lst);
        int                      k;
        int                      old_fill;
        logic signed [SUM_W-1:0] s_ext;
        logic signed [SUM_W-1:0] drop_ext;
        logic signed [SUM_W-1:0] acc;
        logic signed [63:0]      best64;
        logic [63:0]             mag;
        logic [63:0]             quo;
        logic [63:0]             rem;
        logic [63:0]             avg;
        logic [63:0]             k64;
        div_res_t                item;
        k        = eff_len(win_len);
        s_ext    = s;
        acc      = run_sum + s_ext;
        old_fill = fill_cnt;
        if (old_fill >= k)
        begin
            drop_ext = ring[(wr_pos + WMAX - k) % WMAX];
            acc      = acc - drop_ext;
        end
        run_sum      = acc;
        ring[wr_pos] = s;
        wr_pos       = (wr_pos + 1) % WMAX;
        if (fill_cnt < WMAX)
            fill_cnt++;
        if (fill_cnt >= k && (old_fill < k || run_sum > best_sum))
            best_sum = run_sum;
        if (lst)
        begin
            if (fill_cnt < k)
            begin
                item.max_sum     = '0;
                item.max_average = '0;
                item.too_short   = 1'b1;
            end
            else
            begin
                best64 = best_sum;
                mag    = (best_sum < 0) ? -best64 : best64;
                k64    = k;
                quo    = mag / k64;
                rem    = mag % k64;
                avg    = (quo << FRACB) + ((rem << FRACB) / k64);
                if (best_sum < 0)
                    avg = -avg;
                item.max_sum     = best_sum;
                item.max_average = avg[AVG_W-1:0];
                item.too_short   = 1'b0;
            end
            best_q.push_back(item);
            clear_window();
        end
    endtask

    // input side: register writes and accepted samples feed the predictor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                win_len = cfg_wdata;
                clear_window();
            end
            if (smp.valid && smp.ready)
            begin
                window_step(smp.sample, smp.last);
                n_taken++;
            end
        end
    end

    // sample driver
    always @(posedge clk)
    begin : drive
        sample_item_t nxt;
        if (!rst_n)
            smp.valid <= 1'b0;
        else if (!smp.valid || smp.ready)
        begin
            if (sample_q.size() > 0 && (steady || $urandom_range(99) >= 32))
            begin
                nxt = sample_q.pop_front();
                smp.valid  <= 1'b1;
                smp.sample <= nxt.sample;
                smp.last   <= nxt.last;
            end
            else
                smp.valid <= 1'b0;
        end
    end

    // result ready: random idling plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (stall_seen != stall_req)
        begin
            stall_seen <= stall_req;
            hold_left  <= STALL_CYCLES;
            res.ready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else
            res.ready <= steady || ($urandom_range(99) >= 32);
    end

    // result checker
    always @(posedge clk)
    begin : check
        div_res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (best_q.size() == 0)
                flag_mismatch("result with none pending", res.max_sum, 0);
            else
            begin
                want = best_q.pop_front();
                if (res.max_sum !== want.max_sum)
                    flag_mismatch("max_sum", res.max_sum, want.max_sum);
                if (res.max_average !== want.max_average)
                    flag_mismatch("max_average", res.max_average, want.max_average);
                if (res.too_short !== want.too_short)
                    flag_mismatch("too_short", res.too_short, want.too_short);
            end
        end
    end

    task automatic push_item(input logic signed [SAMPLE_W-1:0] s, input logic lst);
        sample_item_t it;
        it.sample = s;
        it.last   = lst;
        sample_q.push_back(it);
        n_queued++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input sample_mix_t mix);
        logic signed [SAMPLE_W-1:0] v;
        case (mix)
            MIX_SMALL:  v = $signed($urandom_range(0, 400)) - 200;
            MIX_CORNER:
                case ($urandom_range(3))
                    0:       v = 32'h7fff_ffff;
                    1:       v = 32'h8000_0000;
                    2:       v = '0;
                    default: v = '1;
                endcase
            MIX_HIGH:   v = 32'h7fff_0000 | $urandom_range(0, 65535);
            MIX_LOW:    v = 32'h8000_0000 | $urandom_range(0, 65535);
            default:    v = $urandom;
        endcase
        return v;
    endfunction

    task automatic push_array(input int len, input sample_mix_t mix);
        for (int i = 0; i < len; i++)
            push_item(rand_sample(mix), i == len - 1);
    endtask

    // register write once the block has gone quiet
    task automatic set_window(input int val);
        while (n_taken != n_queued || best_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wdata <= LEN_W'(val);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // main sequence
    initial
    begin : stim
        int rand_items;
        int phase;
        int wsel;
        int w;
        int k;
        int len;
        int sel;
        int n_arr;
        rand_items = 0;
        phase      = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        smp.valid  = 1'b0;
        smp.sample = '0;
        smp.last   = 1'b0;
        res.ready  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: window of one from reset, extremes, negatives
        push_item(32'h7fff_ffff, 1'b0);
        push_item(32'h8000_0000, 1'b1);
        push_item(-1, 1'b1);
        push_item(32'h8000_0000, 1'b1);
        // zero length acts as one
        set_window(0);
        push_item(5, 1'b0);
        push_item(-7, 1'b1);
        // short array, then a normal one with a fractional average
        set_window(3);
        push_item(1, 1'b0);
        push_item(2, 1'b1);
        push_item(10, 1'b0);
        push_item(-3, 1'b0);
        push_item(4, 1'b0);
        push_item(100, 1'b0);
        push_item(-50, 1'b1);
        // negative average truncates toward zero
        push_item(-10, 1'b0);
        push_item(-10, 1'b0);
        push_item(-11, 1'b1);
        // register write drops the array in progress
        push_item(1000, 1'b0);
        push_item(2000, 1'b0);
        set_window(2);
        push_item(3, 1'b1);
        push_item(-5, 1'b0);
        push_item(-5, 1'b1);

        // full-size window: saturated length, smallest sum, ring wraparound
        set_window(2047);
        for (int i = 0; i < WMAX; i++)
            push_item(32'h8000_0000, 1'b0);
        push_array(6, MIX_FULL);

        // back pressure: receiver holds off while many short arrays queue up
        set_window(4);
        stall_req <= stall_req + 1;
        for (int a = 0; a < 40; a++)
            push_array($urandom_range(4, 7), sample_mix_t'($urandom_range(0, 4)));

        // random phases over a range of window lengths
        while (rand_items < 700)
        begin
            wsel = $urandom_range(99);
            if (wsel < 35)
                w = $urandom_range(1, 4);
            else if (wsel < 75)
                w = $urandom_range(5, 24);
            else if (wsel < 92)
                w = $urandom_range(25, 100);
            else
                w = 0;
            set_window(w);
            k = eff_len(w);
            if (phase == 4)
                steady <= 1'b1;
            else if (phase == 7)
                steady <= 1'b0;
            n_arr = $urandom_range(3, 10);
            for (int a = 0; a < n_arr; a++)
            begin
                sel = $urandom_range(99);
                if (sel < 15 && k > 1)
                    len = $urandom_range(1, k - 1);
                else if (sel < 80)
                    len = $urandom_range(k, k + 12);
                else
                    len = $urandom_range(k, 2 * k + 30);
                push_array(len, sample_mix_t'($urandom_range(0, 4)));
                rand_items += len;
            end
            // sometimes leave a broken array for the next write to drop
            if ($urandom_range(3) == 0)
            begin
                len = $urandom_range(1, k + 3);
                for (int j = 0; j < len; j++)
                    push_item(rand_sample(MIX_FULL), 1'b0);
            end
            phase++;
        end

        // drain and finish
        while (n_taken != n_queued || best_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0 && best_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sliding_window_max_average.f]
rtl/swma_pkg.sv
rtl/swma_if.sv
rtl/swma_div.sv
rtl/sliding_window_max_average.sv
tb/sliding_window_max_average_tb.sv
